[design/sha224_pkg.sv]
// Shared types, constants and round functions for the SHA-224 hasher.
package sha224_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_ADD,
    ST_OUT
  } state_t;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINAL  = 1'b1;

  localparam int BLOCK_BYTES  = 64;
  localparam int LEN_POS      = 56;
  localparam int ROUNDS       = 64;
  localparam int DIGEST_WORDS = 7;
  localparam int FILL_W       = $clog2(BLOCK_BYTES) + 1;
  localparam int RND_W        = $clog2(ROUNDS);
  localparam int COUNT_W      = 61;
  localparam int LEN_W        = 64;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  typedef struct packed {
    logic       byte_shift;
    logic [7:0] byte_in;
    logic       word_shift;
  } msg_ctl_t;

  typedef struct packed {
    logic             init;
    logic             load;
    logic             step;
    logic             accum;
    logic [RND_W-1:0] rnd;
  } rnd_ctl_t;

  function automatic word_t iv_word(input logic [2:0] i);
    word_t r;
    unique case (i)
      3'd0: r = 32'hc1059ed8;
      3'd1: r = 32'h367cd507;
      3'd2: r = 32'h3070dd17;
      3'd3: r = 32'hf70e5939;
      3'd4: r = 32'hffc00b31;
      3'd5: r = 32'h68581511;
      3'd6: r = 32'h64f98fa7;
      3'd7: r = 32'hbefa4fa4;
    endcase
    return r;
  endfunction

  function automatic word_t k_word(input logic [RND_W-1:0] i);
    word_t r;
    unique case (i)
      6'd0:  r = 32'h428A2F98;  6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hB5C0FBCF;  6'd3:  r = 32'hE9B5DBA5;
      6'd4:  r = 32'h3956C25B;  6'd5:  r = 32'h59F111F1;
      6'd6:  r = 32'h923F82A4;  6'd7:  r = 32'hAB1C5ED5;
      6'd8:  r = 32'hD807AA98;  6'd9:  r = 32'h12835B01;
      6'd10: r = 32'h243185BE;  6'd11: r = 32'h550C7DC3;
      6'd12: r = 32'h72BE5D74;  6'd13: r = 32'h80DEB1FE;
      6'd14: r = 32'h9BDC06A7;  6'd15: r = 32'hC19BF174;
      6'd16: r = 32'hE49B69C1;  6'd17: r = 32'hEFBE4786;
      6'd18: r = 32'h0FC19DC6;  6'd19: r = 32'h240CA1CC;
      6'd20: r = 32'h2DE92C6F;  6'd21: r = 32'h4A7484AA;
      6'd22: r = 32'h5CB0A9DC;  6'd23: r = 32'h76F988DA;
      6'd24: r = 32'h983E5152;  6'd25: r = 32'hA831C66D;
      6'd26: r = 32'hB00327C8;  6'd27: r = 32'hBF597FC7;
      6'd28: r = 32'hC6E00BF3;  6'd29: r = 32'hD5A79147;
      6'd30: r = 32'h06CA6351;  6'd31: r = 32'h14292967;
      6'd32: r = 32'h27B70A85;  6'd33: r = 32'h2E1B2138;
      6'd34: r = 32'h4D2C6DFC;  6'd35: r = 32'h53380D13;
      6'd36: r = 32'h650A7354;  6'd37: r = 32'h766A0ABB;
      6'd38: r = 32'h81C2C92E;  6'd39: r = 32'h92722C85;
      6'd40: r = 32'hA2BFE8A1;  6'd41: r = 32'hA81A664B;
      6'd42: r = 32'hC24B8B70;  6'd43: r = 32'hC76C51A3;
      6'd44: r = 32'hD192E819;  6'd45: r = 32'hD6990624;
      6'd46: r = 32'hF40E3585;  6'd47: r = 32'h106AA070;
      6'd48: r = 32'h19A4C116;  6'd49: r = 32'h1E376C08;
      6'd50: r = 32'h2748774C;  6'd51: r = 32'h34B0BCB5;
      6'd52: r = 32'h391C0CB3;  6'd53: r = 32'h4ED8AA4A;
      6'd54: r = 32'h5B9CCA4F;  6'd55: r = 32'h682E6FF3;
      6'd56: r = 32'h748F82EE;  6'd57: r = 32'h78A5636F;
      6'd58: r = 32'h84C87814;  6'd59: r = 32'h8CC70208;
      6'd60: r = 32'h90BEFFFA;  6'd61: r = 32'hA4506CEB;
      6'd62: r = 32'hBEF9A3F7;  6'd63: r = 32'hC67178F2;
    endcase
    return r;
  endfunction

  function automatic word_t big_s0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_s1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_s0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_s1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

[design/sha224_msg.sv]
// Block buffer that fills one byte at a time and then runs the message schedule.
module sha224_msg
  import sha224_pkg::*;
(
  input  logic     clk,
  input  msg_ctl_t ctl,
  output word_t    w_cur
);

  logic [511:0] buf_r;
  logic [511:0] buf_nxt;
  word_t        w0;
  word_t        w1;
  word_t        w9;
  word_t        w14;
  word_t        w_new;

  assign w0    = buf_r[511:480];
  assign w1    = buf_r[479:448];
  assign w9    = buf_r[223:192];
  assign w14   = buf_r[63:32];
  assign w_new = small_s1(w14) + w9 + small_s0(w1) + w0;
  assign w_cur = w0;

  always_comb begin
    buf_nxt = buf_r;
    if (ctl.byte_shift) begin
      buf_nxt = {buf_r[503:0], ctl.byte_in};
    end else if (ctl.word_shift) begin
      buf_nxt = {buf_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule

[design/sha224_round.sv]
// Hash words, working variables and the shared compression round unit.
module sha224_round
  import sha224_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  rnd_ctl_t         ctl,
  input  word_t            w_cur,
  output word_t [7:0]      hash_o
);

  word_t [7:0] hash_r;
  word_t [7:0] hash_nxt;
  word_t [7:0] v_r;
  word_t [7:0] v_nxt;
  word_t       t1;
  word_t       t2;
  word_t       ch;
  word_t       maj;

  assign ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1  = v_r[7] + big_s1(v_r[4]) + ch + k_word(ctl.rnd) + w_cur;
  assign t2  = big_s0(v_r[0]) + maj;

  always_comb begin
    hash_nxt = hash_r;
    v_nxt    = v_r;
    if (ctl.init) begin
      for (int i = 0; i < 8; i++) begin
        hash_nxt[i] = iv_word(3'(i));
      end
    end else if (ctl.accum) begin
      for (int i = 0; i < 8; i++) begin
        hash_nxt[i] = hash_r[i] + v_r[i];
      end
    end
    if (ctl.load) begin
      v_nxt = hash_r;
    end else if (ctl.step) begin
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= iv_word(3'(i));
      end
    end else begin
      hash_r <= hash_nxt;
    end
    v_r <= v_nxt;
  end

  assign hash_o = hash_r;

endmodule

[design/sha224_stream_hasher.sv]
// Top level of the SHA-224 stream hasher: sequencer, padding and digest output.
//
//   Channel  Direction  Payload  Handshake
//   in_      input      in_t     in_valid / in_ready
//   out_     output     out_t    out_valid / out_ready
//
// An absorbed byte is taken in IDLE; the byte that completes a block starts
// compression (64 rounds of the single round unit in COMP and one accumulate in
// ADD; the working variables load in the cycle that takes the byte).
// Finalize pads one byte per cycle up to the length field, shifts in eight length
// bytes, compresses one or two blocks and then offers seven digest transactions.
// Reset is synchronous and loads the initial hash values; out_ready may stall the
// digest words for any time, and no input is taken until the last word is taken.
module sha224_stream_hasher
  import sha224_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  state_t              state_r;
  state_t              state_nxt;
  logic [FILL_W-1:0]   fill_r;
  logic [FILL_W-1:0]   fill_nxt;
  logic [COUNT_W-1:0]  count_r;
  logic [COUNT_W-1:0]  count_nxt;
  logic [LEN_W-1:0]    len_r;
  logic [LEN_W-1:0]    len_nxt;
  logic [RND_W-1:0]    rnd_r;
  logic [RND_W-1:0]    rnd_nxt;
  logic [2:0]          idx_r;
  logic [2:0]          idx_nxt;
  logic                fin_r;
  logic                fin_nxt;
  logic                last_blk_r;
  logic                last_blk_nxt;
  msg_ctl_t            mctl;
  rnd_ctl_t            rctl;
  word_t               w_cur;
  word_t [7:0]         hash;

  sha224_msg u_msg (
    .clk   (clk),
    .ctl   (mctl),
    .w_cur (w_cur)
  );

  sha224_round u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (rctl),
    .w_cur  (w_cur),
    .hash_o (hash)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    fill_nxt        = fill_r;
    count_nxt       = count_r;
    len_nxt         = len_r;
    rnd_nxt         = rnd_r;
    idx_nxt         = idx_r;
    fin_nxt         = fin_r;
    last_blk_nxt    = last_blk_r;
    mctl            = '0;
    rctl            = '0;
    rctl.rnd        = rnd_r;
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mctl.byte_shift = 1'b1;
          fill_nxt        = fill_r + 1'b1;
          if (in_data.opcode == OP_ABSORB) begin
            mctl.byte_in = in_data.data_byte;
            count_nxt    = count_r + 1'b1;
            if (fill_r == FILL_W'(BLOCK_BYTES - 1)) begin
              rctl.load = 1'b1;
              rnd_nxt   = '0;
              state_nxt = ST_COMP;
            end
          end else begin
            mctl.byte_in = PAD_BYTE;
            len_nxt      = {count_r, 3'b000};
            fin_nxt      = 1'b1;
            state_nxt    = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (fill_r == FILL_W'(BLOCK_BYTES)) begin
          rctl.load = 1'b1;
          rnd_nxt   = '0;
          state_nxt = ST_COMP;
        end else if (fill_r == FILL_W'(LEN_POS)) begin
          state_nxt = ST_LEN;
        end else begin
          mctl.byte_shift = 1'b1;
          mctl.byte_in    = ZERO_BYTE;
          fill_nxt        = fill_r + 1'b1;
        end
      end
      ST_LEN: begin
        mctl.byte_shift = 1'b1;
        mctl.byte_in    = len_r[LEN_W-1 -: 8];
        len_nxt         = {len_r[LEN_W-9:0], 8'h00};
        fill_nxt        = fill_r + 1'b1;
        if (fill_r == FILL_W'(BLOCK_BYTES - 1)) begin
          rctl.load    = 1'b1;
          rnd_nxt      = '0;
          last_blk_nxt = 1'b1;
          state_nxt    = ST_COMP;
        end
      end
      ST_COMP: begin
        rctl.step       = 1'b1;
        mctl.word_shift = 1'b1;
        rnd_nxt         = rnd_r + 1'b1;
        if (rnd_r == RND_W'(ROUNDS - 1)) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        rctl.accum = 1'b1;
        fill_nxt   = '0;
        if (last_blk_r) begin
          idx_nxt   = '0;
          state_nxt = ST_OUT;
        end else if (fin_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == 3'(DIGEST_WORDS - 1)) begin
            rctl.init    = 1'b1;
            count_nxt    = '0;
            fill_nxt     = '0;
            fin_nxt      = 1'b0;
            last_blk_nxt = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      count_r    <= '0;
      rnd_r      <= '0;
      idx_r      <= '0;
      fin_r      <= 1'b0;
      last_blk_r <= 1'b0;
    end else begin
      fill_r     <= fill_nxt;
      count_r    <= count_nxt;
      rnd_r      <= rnd_nxt;
      idx_r      <= idx_nxt;
      fin_r      <= fin_nxt;
      last_blk_r <= last_blk_nxt;
    end
    len_r <= len_nxt;
  end

  assign out_data.digest_word = hash[idx_r];
  assign out_data.word_index  = idx_r;
  assign out_data.last_word   = (idx_r == 3'(DIGEST_WORDS - 1));

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("Input accepted while a digest transaction is pending.");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(BLOCK_BYTES))
    else $error("Block fill count exceeds the block size.");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last_word) |=> (in_ready && count_r == '0))
    else $error("Hasher did not return to the initial state after the digest.");

  a_add_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP && rnd_r == RND_W'(ROUNDS - 1)) |=> (state_r == ST_ADD))
    else $error("Compression did not end after the last round.");

endmodule

[bench/sha224_digest_checker.sv]
// Checker that predicts each SHA-224 digest from the input transactions and compares the words.
`timescale 1ns / 100ps

module sha224_digest_checker
  import sha224_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   fail_count,
  output int   words_pending,
  output int   words_checked
);

  localparam logic [0:7][31:0] SHA224_IV = {
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  localparam logic [0:63][31:0] ROUND_K = {
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  word_t             chain_h [8];
  logic [7:0]        msg_block [BLOCK_BYTES];
  int unsigned       fill;
  logic [COUNT_W-1:0] byte_count;
  out_t              digest_q [$];

  function automatic word_t ror32(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic restart_chain();
    for (int i = 0; i < 8; i++) begin
      chain_h[i] = SHA224_IV[i];
    end
    fill = 0;
    byte_count = '0;
  endtask

  task automatic fold_block();
    word_t w [64];
    word_t a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g)) +
           ROUND_K[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endtask

  task automatic absorb_or_finish(input in_t item);
    logic [LEN_W-1:0] bit_len;
    int unsigned      pos;
    out_t             word_exp;
    if (item.opcode == OP_ABSORB) begin
      msg_block[fill] = item.data_byte;
      fill++;
      byte_count++;
      if (fill == BLOCK_BYTES) begin
        fold_block();
        fill = 0;
      end
    end else begin
      bit_len = {byte_count, 3'b000};
      msg_block[fill] = PAD_BYTE;
      pos = fill + 1;
      if (pos > LEN_POS) begin
        while (pos < BLOCK_BYTES) begin
          msg_block[pos] = ZERO_BYTE;
          pos++;
        end
        fold_block();
        pos = 0;
      end
      while (pos < LEN_POS) begin
        msg_block[pos] = ZERO_BYTE;
        pos++;
      end
      for (int k = 0; k < 8; k++) begin
        msg_block[BLOCK_BYTES-1-k] = bit_len[8*k +: 8];
      end
      fold_block();
      for (int k = 0; k < DIGEST_WORDS; k++) begin
        word_exp.digest_word = chain_h[k];
        word_exp.word_index  = 3'(k);
        word_exp.last_word   = (k == DIGEST_WORDS - 1);
        digest_q.push_back(word_exp);
      end
      restart_chain();
    end
  endtask

  always @(posedge clk) begin
    out_t word_exp;
    if (!rst_n) begin
      restart_chain();
      digest_q.delete();
      fail_count = 0;
      words_checked = 0;
      words_pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        words_checked++;
        if (digest_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected digest transaction: expected none, actual %h idx %0d last %0b",
                   $time, out_data.digest_word, out_data.word_index, out_data.last_word);
        end else begin
          word_exp = digest_q.pop_front();
          if (out_data.digest_word !== word_exp.digest_word ||
              out_data.word_index !== word_exp.word_index ||
              out_data.last_word !== word_exp.last_word) begin
            fail_count++;
            $display("%0t: digest mismatch: expected %h idx %0d last %0b, actual %h idx %0d last %0b",
                     $time, word_exp.digest_word, word_exp.word_index, word_exp.last_word,
                     out_data.digest_word, out_data.word_index, out_data.last_word);
          end
        end
      end
      if (in_valid && in_ready) begin
        absorb_or_finish(in_data);
      end
      words_pending = digest_q.size();
    end
  end

endmodule

[bench/tb_sha224_stream_hasher.sv]
// Testbench top for the SHA-224 stream hasher: clock, reset, message stimulus and verdict.
`timescale 1ns / 100ps

module tb_sha224_stream_hasher;
  import sha224_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int LONG_HOLD    = 600;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_AFTER   = 49;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  int fail_count;
  int words_pending;
  int words_checked;

  int burst_left     = 0;
  int items_sent     = 0;
  int messages_sent  = 0;
  int bytes_sent     = 0;
  int spill_messages = 0;
  int idle_cycles    = 0;

  int   hold_left   = 0;
  bit   hold_done   = 1'b0;
  int   words_taken = 0;
  int   mode_left   = 0;
  int   ready_pct   = 100;

  sha224_stream_hasher dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  sha224_digest_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .words_pending(words_pending),
    .words_checked(words_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic offer(input logic op, input logic [7:0] value);
    in_t item;
    int  gap;
    item.opcode = op;
    item.data_byte = value;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic hash_message(input int len);
    for (int i = 0; i < len; i++) begin
      offer(OP_ABSORB, 8'($urandom_range(0, 255)));
    end
    offer(OP_FINAL, 8'($urandom_range(0, 255)));
    messages_sent++;
    bytes_sent += len;
    if (len % BLOCK_BYTES >= LEN_POS) begin
      spill_messages++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        words_taken <= words_taken + 1;
      end
      if (mode_left == 0) begin
        mode_left <= $urandom_range(16, 80);
        case ($urandom_range(0, 3))
          0: ready_pct <= 100;
          1: ready_pct <= 50;
          2: ready_pct <= 20;
          default: ready_pct <= 85;
        endcase
      end else begin
        mode_left <= mode_left - 1;
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && out_valid && words_taken >= HOLD_AFTER) begin
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int start_items;
    int len;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Six messages back to back, two empty; the data byte of a finalize must be ignored.
    offer(OP_FINAL, 8'h00);
    offer(OP_FINAL, 8'hFF);
    offer(OP_ABSORB, 8'h61);
    offer(OP_ABSORB, 8'h62);
    offer(OP_ABSORB, 8'h63);
    offer(OP_FINAL, 8'h5A);
    offer(OP_ABSORB, 8'h00);
    offer(OP_FINAL, 8'h00);
    offer(OP_ABSORB, 8'hFF);
    offer(OP_ABSORB, 8'hFF);
    offer(OP_FINAL, 8'hAA);
    offer(OP_ABSORB, 8'h80);
    offer(OP_ABSORB, 8'h7F);
    offer(OP_FINAL, 8'h01);
    messages_sent += 6;
    bytes_sent += 8;

    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 11))
        0: len = LEN_POS - 1;
        1: len = $urandom_range(LEN_POS, BLOCK_BYTES - 1);
        2: len = BLOCK_BYTES;
        3: len = BLOCK_BYTES - 1;
        4: len = $urandom_range(2 * BLOCK_BYTES - 9, 2 * BLOCK_BYTES);
        5: len = 0;
        default: len = $urandom_range(1, 40);
      endcase
      hash_message(len);
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (words_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("Hashed %0d messages (%0d spilling padding into an extra block), %0d bytes.",
             messages_sent, spill_messages, bytes_sent);
    $display("Compared %0d digest words from %0d input transactions, with one long output stall.",
             words_checked, items_sent);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sha224_stream_hasher.f]
design/sha224_pkg.sv
design/sha224_msg.sv
design/sha224_round.sv
design/sha224_stream_hasher.sv
bench/sha224_digest_checker.sv
bench/tb_sha224_stream_hasher.sv
